// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// The condition must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
	`ASSERT_CLK(label, !(cond), msg)

`endif

// File: sv/gfq_pkg.sv
// ----------------------------------------------------------------------------
// GGA fix quality parser package
// Constants, types and small helper functions shared by the parser files.
// ----------------------------------------------------------------------------
package gfq_pkg;

	localparam int SENTENCE_BYTES = 100;
	localparam int LEN_W = $clog2(SENTENCE_BYTES);
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(SENTENCE_BYTES - 1);
	localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(6);

	localparam int MAG_W = 15;
	localparam logic [MAG_W-1:0] MAG_MAX = '1;

	localparam logic [2:0] FIELD_COMMAS = 3'd6;
	localparam logic [23:0] TAG_GGA = 24'h474741;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_VT = 8'h0B;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;

	typedef enum logic [1:0] {
		PH_BEFORE,
		PH_BLANKS,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic valid;
		logic signed [15:0] value;
	} result_t;

	function automatic logic is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic logic is_line_end(input logic [7:0] c);
		return c == CH_CR || c == CH_LF;
	endfunction

endpackage

// File: sv/gfq_in_reg.sv
// ----------------------------------------------------------------------------
// GGA parser input register
// Holds one received byte until the sentence logic takes it.
// ----------------------------------------------------------------------------
module gfq_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] rx_byte_s1
);

	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			rx_byte_s1 <= rx_byte;
		end
	end

endmodule

// File: sv/gfq_sentence.sv
// ----------------------------------------------------------------------------
// GGA parser sentence state
// Running sentence state and the per-byte update that yields field six.
// ----------------------------------------------------------------------------
module gfq_sentence (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            step,
	input  logic [7:0]      rx_byte_s1,
	output gfq_pkg::result_t result
);

	import gfq_pkg::*;

	logic [LEN_W-1:0] length_q, length_d;
	logic [2:0]       commas_q, commas_d;
	logic [23:0]      recent_q, recent_d;
	logic             gga_q, gga_d;
	phase_t           phase_q, phase_d;
	logic             minus_q, minus_d;
	logic [MAG_W-1:0] mag_q, mag_d;
	logic             ended_q, ended_d;

	logic [MAG_W+3:0] mag_next;
	logic [MAG_W-1:0] mag_sat;
	logic [15:0]      mag_ext;

	assign mag_next = (MAG_W+4)'(mag_q) * (MAG_W+4)'(10)
		+ (MAG_W+4)'(rx_byte_s1 - CH_ZERO);
	assign mag_sat = (mag_next > (MAG_W+4)'(MAG_MAX)) ? MAG_MAX : mag_next[MAG_W-1:0];
	assign mag_ext = {1'b0, mag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= '0;
			commas_q <= '0;
			recent_q <= '0;
			gga_q    <= 1'b0;
			phase_q  <= PH_BEFORE;
			minus_q  <= 1'b0;
			mag_q    <= '0;
			ended_q  <= 1'b0;
		end else if (step) begin
			length_q <= length_d;
			commas_q <= commas_d;
			recent_q <= recent_d;
			gga_q    <= gga_d;
			phase_q  <= phase_d;
			minus_q  <= minus_d;
			mag_q    <= mag_d;
			ended_q  <= ended_d;
		end
	end

	always_comb begin
		length_d = length_q;
		commas_d = commas_q;
		recent_d = recent_q;
		gga_d    = gga_q;
		phase_d  = phase_q;
		minus_d  = minus_q;
		mag_d    = mag_q;
		ended_d  = ended_q;
		result.valid = 1'b0;
		result.value = minus_q ? -$signed(mag_ext) : $signed(mag_ext);

		if (rx_byte_s1 == CH_DOLLAR) begin
			length_d = LEN_W'(1);
			commas_d = '0;
			recent_d = {16'h0000, CH_DOLLAR};
			gga_d    = 1'b0;
			phase_d  = PH_BEFORE;
			minus_d  = 1'b0;
			mag_d    = '0;
			ended_d  = 1'b0;
		end else if (is_line_end(rx_byte_s1) || length_q >= LEN_LIMIT) begin
			result.valid = is_line_end(rx_byte_s1) && length_q > LEN_MIN && gga_q;
			length_d = '0;
			commas_d = '0;
			recent_d = '0;
			gga_d    = 1'b0;
			phase_d  = PH_BEFORE;
			minus_d  = 1'b0;
			mag_d    = '0;
			ended_d  = 1'b0;
		end else begin
			length_d = length_q + LEN_W'(1);
			if (!ended_q) begin
				if (rx_byte_s1 == CH_NUL) begin
					ended_d = 1'b1;
				end else begin
					case (phase_q)
						PH_BLANKS: begin
							if (rx_byte_s1 == CH_PLUS || rx_byte_s1 == CH_MINUS) begin
								minus_d = (rx_byte_s1 == CH_MINUS);
								phase_d = PH_DIGITS;
							end else if (is_digit(rx_byte_s1)) begin
								mag_d   = mag_sat;
								phase_d = PH_DIGITS;
							end else if (!is_blank(rx_byte_s1)) begin
								phase_d = PH_DONE;
							end
						end
						PH_DIGITS: begin
							if (is_digit(rx_byte_s1)) begin
								mag_d = mag_sat;
							end else begin
								phase_d = PH_DONE;
							end
						end
						default: begin
						end
					endcase
					if (rx_byte_s1 == CH_COMMA) begin
						if (recent_q == TAG_GGA) begin
							gga_d = 1'b1;
						end
						if (commas_q < FIELD_COMMAS) begin
							commas_d = commas_q + 3'd1;
							if (commas_q + 3'd1 == FIELD_COMMAS) begin
								phase_d = PH_BLANKS;
							end
						end
					end
					recent_d = {recent_q[15:0], rx_byte_s1};
				end
			end
		end
	end

endmodule

// File: sv/gfq_out_reg.sv
// ----------------------------------------------------------------------------
// GGA parser output register
// Holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module gfq_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                valid_s1,
	output logic                advance,
	input  gfq_pkg::result_t    result,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [15:0]  fix_quality
);

	import gfq_pkg::*;

	logic               out_valid_s2;
	logic signed [15:0] fix_quality_s2;

	assign advance     = valid_s1 && (!out_valid_s2 || out_ready);
	assign out_valid   = out_valid_s2;
	assign fix_quality = fix_quality_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= result.valid;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && result.valid) begin
			fix_quality_s2 <= result.value;
		end
	end

endmodule

// File: sv/gga_fix_quality_parser.sv
// ----------------------------------------------------------------------------
// GGA fix quality parser
// Follows an NMEA byte stream and reports field six of each GGA sentence.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------
//  input    | in_valid, in_ready  | rx_byte (8 bits)
//  output   | out_valid, out_ready| fix_quality (16 bits, signed)
//
// A byte is registered, then updates the sentence state when it advances.
// A line end closing a GGA sentence raises out_valid from the output register.
// One byte is taken per cycle while the output register is free or draining.
// A held result stalls the byte in the input register and then in_ready.
// Reset clears the sentence state and empties both registers.
// ----------------------------------------------------------------------------
module gga_fix_quality_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] fix_quality
);

	import gfq_pkg::*;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       advance;
	result_t    result;

	gfq_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.rx_byte_s1(rx_byte_s1)
	);

	gfq_sentence u_sentence (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.rx_byte_s1(rx_byte_s1),
		.result    (result)
	);

	gfq_out_reg u_out_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.advance    (advance),
		.result     (result),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.fix_quality(fix_quality)
	);

endmodule

// File: sv/gfq_checker.sv
// ----------------------------------------------------------------------------
// GGA parser port checker
// Checks the parser's ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gfq_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [7:0]         rx_byte,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [15:0] fix_quality
);

	import gfq_pkg::*;

	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(fix_quality), "Result item changed while stalled.")
	`ASSERT_CLK(a_out_after_in, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "Result item without a byte two cycles earlier.")
	`ASSERT_CLK(a_out_line_end, $rose(out_valid) |-> ($past(rx_byte, 2) == CH_CR || $past(rx_byte, 2) == CH_LF), "Result item not caused by a line end.")
	`ASSERT_NEVER(a_out_range, out_valid && fix_quality == 16'sh8000, "Result item outside the saturated range.")

endmodule

bind gga_fix_quality_parser gfq_checker u_gfq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.rx_byte    (rx_byte),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.fix_quality(fix_quality)
);
